>>> src/ttr_pkg.sv
// Shared types and constants of the truncated time reconstructor.
package ttr_pkg;

   localparam int SOURCE_BITS = 16;
   localparam int TIME_BITS = 24;
   localparam int RAM_WIDTH = TIME_BITS + 1;
   localparam int RAM_DEPTH = 65536;
   localparam int NUM_CANDS = 5;

   localparam logic [TIME_BITS-1:0] DAY_TICKS = 24'd11059200;
   localparam logic [TIME_BITS-1:0] HALF_PERIOD_TICKS = 24'd32768;
   localparam logic [TIME_BITS-1:0] FINAL_PERIOD_START = 24'd11010048;

   typedef enum logic {
      CMD_REFERENCE = 1'b0,
      CMD_PLOT = 1'b1
   } ttr_command_type;

   typedef enum logic [2:0] {
      STATUS_UNCHANGED = 3'd0,
      STATUS_REBUILT = 3'd1,
      STATUS_COPIED = 3'd2,
      STATUS_AMBIGUOUS = 3'd3,
      STATUS_STORED = 3'd4,
      STATUS_REJECTED = 3'd5
   } ttr_status_type;

   typedef struct packed {
      logic accept;
      logic adv2;
      logic adv3;
      logic load_out;
      logic clear_we;
   } ttr_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ttr_stat_type;

   typedef struct packed {
      logic is_plot;
      logic known;
      logic time_present;
      logic [15:0] trunc_time;
      logic [7:0] sac;
      logic [7:0] sic;
      ttr_status_type ref_status;
   } ttr_s1_type;

   typedef struct packed {
      logic need_rebuild;
      ttr_status_type status;
      logic known;
      logic [7:0] sac;
      logic [7:0] sic;
      logic [TIME_BITS-1:0] tval;
      logic [NUM_CANDS-1:0] cand_ok;
      logic [NUM_CANDS-1:0][TIME_BITS-1:0] cand;
      logic [NUM_CANDS-1:0][TIME_BITS:0] diff;
   } ttr_s2_type;

   typedef struct packed {
      logic need_rebuild;
      ttr_status_type status;
      logic known;
      logic [7:0] sac;
      logic [7:0] sic;
      logic [TIME_BITS-1:0] tval;
      logic [NUM_CANDS-1:0][TIME_BITS-1:0] cand;
      logic [NUM_CANDS-1:0][TIME_BITS-1:0] distance;
   } ttr_s3_type;

endpackage

>>> src/ttr_ram.sv
// Generic single-port-write, registered-read RAM.
module ttr_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ttr_ctrl.sv
// Controller: clearing sweep after reset and pipeline occupancy tracking.
module ttr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ttr_pkg::ttr_stat_type stat,
   output ttr_pkg::ttr_cmd_type  cmd
);

   typedef enum logic {
      CLEAR,
      RUN
   } state_type;

   state_type state_ff, state_in;
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic vo_ff, vo_in;
   logic open;

   always_comb begin
      cmd.load_out = v3_ff && (!vo_ff || !rsp_stall);
      cmd.adv3 = v2_ff && (!v3_ff || cmd.load_out);
      cmd.adv2 = v1_ff && (!v2_ff || cmd.adv3);
      open = (state_ff == RUN) && (!v1_ff || cmd.adv2);
      cmd.accept = open && req_valid;
      cmd.clear_we = (state_ff == CLEAR);

      v1_in = cmd.accept || (v1_ff && !cmd.adv2);
      v2_in = cmd.adv2 || (v2_ff && !cmd.adv3);
      v3_in = cmd.adv3 || (v3_ff && !cmd.load_out);
      vo_in = cmd.load_out || (vo_ff && rsp_stall);

      state_in = state_ff;
      case (state_ff)
         CLEAR: begin
            if (stat.clear_last) begin
               state_in = RUN;
            end
         end
         RUN: begin
            state_in = RUN;
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   assign req_stall = !open;
   assign rsp_valid = vo_ff;

endmodule

>>> src/ttr_datapath.sv
// Datapath: source tracking, reference table and candidate selection pipeline.
module ttr_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ttr_pkg::ttr_cmd_type  cmd,
   output ttr_pkg::ttr_stat_type stat,
   input  logic                  req_command,
   input  logic                  req_block_start,
   input  logic                  req_source_present,
   input  logic [7:0]            req_sac,
   input  logic [7:0]            req_sic,
   input  logic                  req_time_present,
   input  logic [23:0]           req_full_time,
   input  logic [15:0]           req_trunc_time,
   output logic [2:0]            rsp_status,
   output logic [7:0]            rsp_out_sac,
   output logic [7:0]            rsp_out_sic,
   output logic                  rsp_source_known,
   output logic [23:0]           rsp_time_value
);

   localparam int AW = ttr_pkg::SOURCE_BITS;
   localparam int TW = ttr_pkg::TIME_BITS;
   localparam int NC = ttr_pkg::NUM_CANDS;

   logic [7:0] carried_sac_ff, carried_sac_in;
   logic [7:0] carried_sic_ff, carried_sic_in;
   logic carried_valid_ff, carried_valid_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   ttr_pkg::ttr_s1_type s1_ff, s1_in;
   ttr_pkg::ttr_s2_type s2_ff, s2_in;
   ttr_pkg::ttr_s3_type s3_ff, s3_in;

   ttr_pkg::ttr_status_type status_ff, status_in;
   logic [7:0] out_sac_ff, out_sac_in;
   logic [7:0] out_sic_ff, out_sic_in;
   logic known_ff, known_in;
   logic [TW-1:0] tval_ff, tval_in;

   logic is_plot;
   logic carried_live;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [ttr_pkg::RAM_WIDTH-1:0] wr_data;
   logic [ttr_pkg::RAM_WIDTH-1:0] rd_data;
   logic store_ok;

   logic [TW-1:0] ref_time;
   logic [7:0] ref_hi;
   logic [8:0] hi_next;
   logic [TW:0] cand2_wide;
   logic [TW:0] dabs;
   logic [TW:0] wrap;
   logic [2:0] m01, m23, m03, best;
   logic best_ok;

   ttr_ram #(
      .WIDTH(ttr_pkg::RAM_WIDTH),
      .DEPTH(ttr_pkg::RAM_DEPTH)
   ) u_ref_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(cmd.accept),
      .rd_addr({s1_in.sac, s1_in.sic}),
      .rd_data(rd_data)
   );

   // Accept stage: source selection, table write and table read.
   always_comb begin
      is_plot = (req_command == ttr_pkg::CMD_PLOT);
      carried_live = carried_valid_ff && !req_block_start;

      s1_in.is_plot = is_plot;
      s1_in.time_present = req_time_present;
      s1_in.trunc_time = req_trunc_time;
      if (req_source_present) begin
         s1_in.known = 1'b1;
         s1_in.sac = req_sac;
         s1_in.sic = req_sic;
      end else if (is_plot && carried_live) begin
         s1_in.known = 1'b1;
         s1_in.sac = carried_sac_ff;
         s1_in.sic = carried_sic_ff;
      end else begin
         s1_in.known = 1'b0;
         s1_in.sac = 8'd0;
         s1_in.sic = 8'd0;
      end

      store_ok = req_full_time < ttr_pkg::DAY_TICKS;
      if (req_source_present && req_time_present) begin
         s1_in.ref_status = store_ok ? ttr_pkg::STATUS_STORED : ttr_pkg::STATUS_REJECTED;
      end else begin
         s1_in.ref_status = ttr_pkg::STATUS_UNCHANGED;
      end

      carried_sac_in = carried_sac_ff;
      carried_sic_in = carried_sic_ff;
      carried_valid_in = carried_valid_ff;
      if (cmd.accept) begin
         carried_valid_in = carried_live;
         if (is_plot && req_source_present) begin
            carried_sac_in = req_sac;
            carried_sic_in = req_sic;
            carried_valid_in = 1'b1;
         end
      end

      if (cmd.clear_we) begin
         wr_en = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_en = cmd.accept && !is_plot && req_source_present && req_time_present
                 && store_ok;
         wr_addr = {req_sac, req_sic};
         wr_data = {1'b1, req_full_time};
      end

      clear_addr_in = cmd.clear_we ? clear_addr_ff + 1'b1 : clear_addr_ff;
      stat.clear_last = &clear_addr_ff;
   end

   // Second stage: status decision and candidate offsets.
   always_comb begin
      ref_time = rd_data[TW-1:0];
      ref_hi = ref_time[TW-1:TW-8];
      hi_next = {1'b0, ref_hi} + 9'd1;
      cand2_wide = {hi_next, s1_ff.trunc_time};

      s2_in.known = s1_ff.known;
      s2_in.sac = s1_ff.sac;
      s2_in.sic = s1_ff.sic;
      s2_in.need_rebuild = 1'b0;
      s2_in.tval = '0;
      if (!s1_ff.is_plot) begin
         s2_in.status = s1_ff.ref_status;
      end else if (!s1_ff.known || !rd_data[TW]) begin
         s2_in.status = ttr_pkg::STATUS_UNCHANGED;
      end else if (!s1_ff.time_present) begin
         s2_in.status = ttr_pkg::STATUS_COPIED;
         s2_in.tval = ref_time;
      end else begin
         s2_in.status = ttr_pkg::STATUS_REBUILT;
         s2_in.need_rebuild = 1'b1;
      end

      s2_in.cand[0] = {ref_hi - 8'd1, s1_ff.trunc_time};
      s2_in.cand[1] = {ref_hi, s1_ff.trunc_time};
      s2_in.cand[2] = cand2_wide[TW-1:0];
      s2_in.cand[3] = {8'd0, s1_ff.trunc_time};
      s2_in.cand[4] = ttr_pkg::FINAL_PERIOD_START + {8'd0, s1_ff.trunc_time};

      s2_in.cand_ok[0] = (ref_hi != 8'd0);
      s2_in.cand_ok[1] = s2_in.cand[1] < ttr_pkg::DAY_TICKS;
      s2_in.cand_ok[2] = cand2_wide < {1'b0, ttr_pkg::DAY_TICKS};
      s2_in.cand_ok[3] = 1'b1;
      s2_in.cand_ok[4] = s2_in.cand[4] < ttr_pkg::DAY_TICKS;

      for (int i = 0; i < NC; i++) begin
         s2_in.diff[i] = {1'b0, s2_in.cand[i]} - {1'b0, ref_time};
      end
   end

   // Third stage: circular distance on the day.
   always_comb begin
      s3_in.need_rebuild = s2_ff.need_rebuild;
      s3_in.status = s2_ff.status;
      s3_in.known = s2_ff.known;
      s3_in.sac = s2_ff.sac;
      s3_in.sic = s2_ff.sic;
      s3_in.tval = s2_ff.tval;
      s3_in.cand = s2_ff.cand;
      dabs = '0;
      wrap = '0;
      for (int i = 0; i < NC; i++) begin
         dabs = s2_ff.diff[i][TW] ? ({(TW+1){1'b0}} - s2_ff.diff[i]) : s2_ff.diff[i];
         wrap = {1'b0, ttr_pkg::DAY_TICKS} - dabs;
         if (!s2_ff.cand_ok[i]) begin
            s3_in.distance[i] = '1;
         end else if (wrap < dabs) begin
            s3_in.distance[i] = wrap[TW-1:0];
         end else begin
            s3_in.distance[i] = dabs[TW-1:0];
         end
      end
   end

   // Output stage: first nearest candidate and the ambiguity threshold.
   always_comb begin
      m01 = (s3_ff.distance[1] < s3_ff.distance[0]) ? 3'd1 : 3'd0;
      m23 = (s3_ff.distance[3] < s3_ff.distance[2]) ? 3'd3 : 3'd2;
      m03 = (s3_ff.distance[m23] < s3_ff.distance[m01]) ? m23 : m01;
      best = (s3_ff.distance[4] < s3_ff.distance[m03]) ? 3'd4 : m03;
      best_ok = s3_ff.distance[best] < ttr_pkg::HALF_PERIOD_TICKS;

      out_sac_in = s3_ff.sac;
      out_sic_in = s3_ff.sic;
      known_in = s3_ff.known;
      if (s3_ff.need_rebuild) begin
         status_in = best_ok ? ttr_pkg::STATUS_REBUILT : ttr_pkg::STATUS_AMBIGUOUS;
         tval_in = best_ok ? s3_ff.cand[best] : '0;
      end else begin
         status_in = s3_ff.status;
         tval_in = s3_ff.tval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carried_sac_ff <= 8'd0;
         carried_sic_ff <= 8'd0;
         carried_valid_ff <= 1'b0;
         clear_addr_ff <= '0;
      end else begin
         carried_sac_ff <= carried_sac_in;
         carried_sic_ff <= carried_sic_in;
         carried_valid_ff <= carried_valid_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s1_ff <= s1_in;
      end
      if (cmd.adv2) begin
         s2_ff <= s2_in;
      end
      if (cmd.adv3) begin
         s3_ff <= s3_in;
      end
      if (cmd.load_out) begin
         status_ff <= status_in;
         out_sac_ff <= out_sac_in;
         out_sic_ff <= out_sic_in;
         known_ff <= known_in;
         tval_ff <= tval_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_out_sac = out_sac_ff;
   assign rsp_out_sic = out_sic_ff;
   assign rsp_source_known = known_ff;
   assign rsp_time_value = tval_ff;

endmodule

>>> src/truncated_time_reconstructor_unit.sv
// Top level of the truncated time reconstructor.
//
//   Channel   Prefix  Direction  Contents
//   request   req_    in         record: command, block, source, time fields
//   response  rsp_    out        status, source used, rebuilt time of day
//
// One record is taken per cycle while req_stall is low; its result passes through s1, s2, s3 and the output register.
// The reference table is one 65536 x 25 RAM, written and read at the request transfer.
// After reset a clearing pass writes every table entry, with req_stall high until it ends.
// A stalled response holds the pipeline stages behind it, then the request side.
module truncated_time_reconstructor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic        req_block_start,
   input  logic        req_source_present,
   input  logic [7:0]  req_sac,
   input  logic [7:0]  req_sic,
   input  logic        req_time_present,
   input  logic [23:0] req_full_time,
   input  logic [15:0] req_trunc_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_sac,
   output logic [7:0]  rsp_out_sic,
   output logic        rsp_source_known,
   output logic [23:0] rsp_time_value
);

   ttr_pkg::ttr_cmd_type cmd;
   ttr_pkg::ttr_stat_type stat;

   ttr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat(stat),
      .cmd(cmd)
   );

   ttr_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_command(req_command),
      .req_block_start(req_block_start),
      .req_source_present(req_source_present),
      .req_sac(req_sac),
      .req_sic(req_sic),
      .req_time_present(req_time_present),
      .req_full_time(req_full_time),
      .req_trunc_time(req_trunc_time),
      .rsp_status(rsp_status),
      .rsp_out_sac(rsp_out_sac),
      .rsp_out_sic(rsp_out_sic),
      .rsp_source_known(rsp_source_known),
      .rsp_time_value(rsp_time_value)
   );

endmodule
